// ===== src/bcf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcf_pkg
// Types and constants shared by the canonical bracelet form block.
// ----------------------------------------------------------------------------
package bcf_pkg;

  localparam int unsigned MAX_ORDER_DEF = 32;
  localparam int unsigned ELEM_W        = 16;
  localparam int unsigned POS_W         = 5;
  localparam int unsigned ORDER_W       = 6;
  localparam int unsigned ORDER_RESET   = 3;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_PICK_RD,
    ST_PICK_CMP,
    ST_EMIT_RD,
    ST_EMIT_WR
  } bcf_state_e;

endpackage

// ===== src/bracelet_canonical_form_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bracelet_canonical_form_top
// Collects n elements of a cyclic sequence and emits its canonical bracelet.
// Steps: n input beats are loaded, then a forward and a reflected
// least-rotation scan run, each step a registered memory read and a
// compare, then a tie-break pass picks the smaller rotation and the n
// elements are emitted, each by a memory read and a stallable output write.
// One sequence at a time: no new sequence loads until emission ends.
// Reset clears the control state and sets the order to 3, not the memory.
// ----------------------------------------------------------------------------
module bracelet_canonical_form_top import bcf_pkg::*; #(
  parameter int unsigned MAX_ORDER = MAX_ORDER_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write channel.
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [ORDER_W-1:0]  cfg_data_i,
  // Element input channel.
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ELEM_W-1:0]   element_value_i,
  // Canonical sequence output channel.
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ELEM_W-1:0]   canon_value_o,
  output logic [POS_W-1:0]    position_o,
  output logic                last_o
);

  localparam int unsigned AW = $clog2(MAX_ORDER);
  localparam int unsigned CW = $clog2(MAX_ORDER + 1);
  localparam int unsigned SW = CW + 1;

  bcf_state_e state_q, state_d;

  logic [CW-1:0]     n_q, n_d;
  logic [CW-1:0]     load_cnt_q, load_cnt_d;
  logic [SW-1:0]     i_q, i_d;
  logic [SW-1:0]     j_q, j_d;
  logic [CW-1:0]     k_q, k_d;
  logic              scan_rev_q, scan_rev_d;
  logic [AW-1:0]     rot_f_q, rot_f_d;
  logic [AW-1:0]     rot_r_q, rot_r_d;
  logic [CW-1:0]     p_q, p_d;
  logic              pick_rev_q, pick_rev_d;

  logic              out_valid_q, out_valid_d;
  logic [ELEM_W-1:0] out_value_q, out_value_d;
  logic [POS_W-1:0]  out_pos_q, out_pos_d;
  logic              out_last_q, out_last_d;

  logic [ELEM_W-1:0] seq_mem_q [MAX_ORDER];
  logic [ELEM_W-1:0] rd_a_q, rd_b_q;
  logic [AW-1:0]     addr_a, addr_b;

  logic              cfg_we, in_acc, load_done, out_free;
  logic              scan_go, emit_last;
  logic [SW-1:0]     n_sw;
  logic [SW-1:0]     scan_min;
  logic [SW-1:0]     i_step, j_step;
  logic [AW-1:0]     xa, xb, xf, xr;
  logic [ORDER_W:0]  cfg_ext;

  // Wrap a value below twice the order back into the sequence.
  function automatic logic [AW-1:0] wrap_idx(input logic [SW-1:0] x,
                                             input logic [SW-1:0] nn);
    logic [SW-1:0] r;
    r = (x >= nn) ? (x - nn) : x;
    return AW'(r);
  endfunction

  // Reflected sequence keeps element 0 and reverses the rest.
  function automatic logic [AW-1:0] refl_idx(input logic [AW-1:0] x,
                                             input logic [SW-1:0] nn);
    logic [SW-1:0] r;
    r = (x == '0) ? '0 : (nn - SW'(x));
    return AW'(r);
  endfunction

  assign n_sw      = SW'(n_q);
  assign cfg_ready_o = (state_q == ST_LOAD);
  assign cfg_we    = cfg_valid_i && cfg_ready_o;
  // A configuration beat takes priority over an element beat.
  assign in_stall_o = (state_q != ST_LOAD) || cfg_valid_i;
  assign in_acc    = in_valid_i && !in_stall_o;
  assign load_done = (load_cnt_q + CW'(1)) == n_q;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign emit_last = (p_q + CW'(1)) == n_q;
  assign scan_go   = (i_q < n_sw) && (j_q < n_sw) && (k_q < n_q);
  assign scan_min  = (i_q < j_q) ? i_q : j_q;
  assign cfg_ext   = {1'b0, cfg_data_i};

  assign i_step = i_q + SW'(k_q) + SW'(1);
  assign j_step = j_q + SW'(k_q) + SW'(1);

  // Address generation for both read ports.
  assign xa = wrap_idx(i_q + SW'(k_q), n_sw);
  assign xb = wrap_idx(j_q + SW'(k_q), n_sw);
  assign xf = wrap_idx(SW'(p_q) + SW'(rot_f_q), n_sw);
  assign xr = refl_idx(wrap_idx(SW'(p_q) + SW'(rot_r_q), n_sw), n_sw);

  always_comb begin
    case (state_q)
      ST_SCAN_RD, ST_SCAN_CMP: begin
        addr_a = scan_rev_q ? refl_idx(xa, n_sw) : xa;
        addr_b = scan_rev_q ? refl_idx(xb, n_sw) : xb;
      end
      ST_EMIT_RD, ST_EMIT_WR: begin
        addr_a = pick_rev_q ? xr : xf;
        addr_b = xr;
      end
      default: begin
        addr_a = xf;
        addr_b = xr;
      end
    endcase
  end

  // Sequence memory: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      seq_mem_q[AW'(load_cnt_q)] <= element_value_i;
    end
    rd_a_q <= seq_mem_q[addr_a];
    rd_b_q <= seq_mem_q[addr_b];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (in_acc && load_done) state_d = ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        if (scan_go) state_d = ST_SCAN_CMP;
        else if (scan_rev_q) state_d = ST_PICK_RD;
      end
      ST_SCAN_CMP: state_d = ST_SCAN_RD;
      ST_PICK_RD: begin
        state_d = (p_q == n_q) ? ST_EMIT_RD : ST_PICK_CMP;
      end
      ST_PICK_CMP: begin
        state_d = (rd_a_q != rd_b_q) ? ST_EMIT_RD : ST_PICK_RD;
      end
      ST_EMIT_RD: state_d = ST_EMIT_WR;
      ST_EMIT_WR: begin
        if (out_free) state_d = emit_last ? ST_LOAD : ST_EMIT_RD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // Datapath and output register updates.
  always_comb begin
    n_d         = n_q;
    load_cnt_d  = load_cnt_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    scan_rev_d  = scan_rev_q;
    rot_f_d     = rot_f_q;
    rot_r_d     = rot_r_q;
    p_d         = p_q;
    pick_rev_d  = pick_rev_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_value_d = out_value_q;
    out_pos_d   = out_pos_q;
    out_last_d  = out_last_q;

    case (state_q)
      ST_LOAD: begin
        if (cfg_we) begin
          if (cfg_data_i == '0) begin
            n_d = CW'(1);
          end else if (cfg_ext > (ORDER_W+1)'(MAX_ORDER)) begin
            n_d = CW'(MAX_ORDER);
          end else begin
            n_d = CW'(cfg_data_i);
          end
          load_cnt_d = '0;
        end else if (in_acc) begin
          if (load_done) begin
            load_cnt_d = '0;
            i_d        = '0;
            j_d        = SW'(1);
            k_d        = '0;
            scan_rev_d = 1'b0;
          end else begin
            load_cnt_d = load_cnt_q + CW'(1);
          end
        end
      end
      ST_SCAN_RD: begin
        if (!scan_go) begin
          if (scan_rev_q) begin
            rot_r_d = AW'(scan_min);
            p_d     = '0;
          end else begin
            rot_f_d    = AW'(scan_min);
            i_d        = '0;
            j_d        = SW'(1);
            k_d        = '0;
            scan_rev_d = 1'b1;
          end
        end
      end
      ST_SCAN_CMP: begin
        if (rd_a_q == rd_b_q) begin
          k_d = k_q + CW'(1);
        end else if (rd_a_q > rd_b_q) begin
          i_d = (i_step == j_q) ? (i_step + SW'(1)) : i_step;
          k_d = '0;
        end else begin
          j_d = (j_step == i_q) ? (j_step + SW'(1)) : j_step;
          k_d = '0;
        end
      end
      ST_PICK_RD: begin
        if (p_q == n_q) begin
          pick_rev_d = 1'b0;
          p_d        = '0;
        end
      end
      ST_PICK_CMP: begin
        if (rd_a_q != rd_b_q) begin
          pick_rev_d = rd_b_q < rd_a_q;
          p_d        = '0;
        end else begin
          p_d = p_q + CW'(1);
        end
      end
      ST_EMIT_WR: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = rd_a_q;
          out_pos_d   = POS_W'(p_q);
          out_last_d  = emit_last;
          p_d         = p_q + CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      n_q         <= CW'(ORDER_RESET);
      load_cnt_q  <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      scan_rev_q  <= 1'b0;
      rot_f_q     <= '0;
      rot_r_q     <= '0;
      p_q         <= '0;
      pick_rev_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      load_cnt_q  <= load_cnt_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      scan_rev_q  <= scan_rev_d;
      rot_f_q     <= rot_f_d;
      rot_r_q     <= rot_r_d;
      p_q         <= p_d;
      pick_rev_q  <= pick_rev_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    out_pos_q   <= out_pos_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign canon_value_o = out_value_q;
  assign position_o    = out_pos_q;
  assign last_o        = out_last_q;

  // The fill count never reaches the order while elements are loading.
  a_load_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> (load_cnt_q < n_q))
    else $error("load count reached the order");

  // The two scan candidates never coincide during a compare.
  a_scan_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN_CMP) |-> (i_q != j_q))
    else $error("scan pointers collided");

  // Emission never runs past the end of the sequence.
  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT_WR) |-> (p_q < n_q))
    else $error("emit index beyond order");

  // The beat that completes a sequence starts the forward scan.
  a_load_to_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && load_done) |=> (state_q == ST_SCAN_RD) && !scan_rev_q)
    else $error("full load did not start the scan");

endmodule
